[sv/wfba_pkg.sv]
// Package for the worst-fit block allocator: widths, commands and shared types.
package wfba_pkg;

    localparam int MaxBlocksDefault = 32;
    localparam int MaxGapsDefault   = 33;
    localparam int AddrBitsDefault  = 16;

    localparam int CmdW  = 3;
    localparam int SizeW = 17;
    localparam int AddrW = 16;

    typedef enum logic [CmdW-1:0] {
        CMD_ALLOC  = 3'd0,
        CMD_FREE   = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_EXACT  = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

endpackage

[sv/wfba_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module wfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/worst_fit_block_allocator_unit.sv]
// Top level of the worst-fit block allocator with coalescing free.
//
//  channel   dir  payload
//  s_axis    in   tdata = command, req_size, req_addr (36 bits, 40 packed)
//  m_axis    out  tdata = ok, block_addr, offset, free_words, top_address (67 bits, 72 packed)
//  cfg       in   cfg_wr_en / cfg_wr_data = total_size
//
// A command that needs no table walk passes from its transfer through S_DISP, S_TOP,
// S_TOPW and S_OUT to a valid result; the longest commands are allocs that scan the
// gaps, shift the block table and close an exhausted gap. A scan step takes one cycle
// per entry; a move or compare step waits for the registered RAM read.
// Reset (aresetn low, synchronous) empties the block table and leaves one gap over the
// full span; no clearing pass is needed, since entries above the counts are never used.
// s_axis_tready stays low while a command runs and while a result waits on m_axis.
module worst_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS = wfba_pkg::MaxBlocksDefault,
    parameter int MAX_GAPS   = wfba_pkg::MaxGapsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command [2:0], req_size [19:3], req_addr [35:20], zero fill
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ok [0], block_addr [16:1], offset [32:17], free_words [49:33],
    // top_address [66:50], zero fill
    output logic [71:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);
    import wfba_pkg::*;

    localparam int ADDR_BITS = AddrBitsDefault;
    localparam int BI = $clog2(MAX_BLOCKS);
    localparam int GI = $clog2(MAX_GAPS);
    localparam int BC = $clog2(MAX_BLOCKS + 1);
    localparam int GC = $clog2(MAX_GAPS + 1);
    localparam int LW = ADDR_BITS + 1;
    localparam logic [LW-1:0] Span = LW'(1) << ADDR_BITS;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DISP   = 13'b0000000000010,
        S_GSCAN  = 13'b0000000000100,
        S_BSHIFT = 13'b0000000001000,
        S_GDEL   = 13'b0000000010000,
        S_BFIND  = 13'b0000000100000,
        S_GFIND  = 13'b0000001000000,
        S_GINS   = 13'b0000010000000,
        S_BDEL   = 13'b0000100000000,
        S_LOOK   = 13'b0001000000000,
        S_TOP    = 13'b0010000000000,
        S_TOPW   = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Command registers.
    logic [CmdW-1:0]      cmd_reg;
    logic [LW-1:0]        size_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [LW-1:0]        total_reg, used_reg, used_next;
    logic [BC-1:0]        bcnt_reg, bcnt_next;
    logic [GC-1:0]        gcnt_reg, gcnt_next;
    logic [GC-1:0]        gi_reg, gi_next;
    logic [BC-1:0]        bi_reg, bi_next;
    logic                 rv_reg, rv_next; // read data of this cycle is valid
    logic [GI-1:0]        best_reg, best_next;
    logic [LW-1:0]        bestlen_reg, bestlen_next;
    logic [ADDR_BITS-1:0] bestbase_reg, bestbase_next;
    logic [LW-1:0]        flen_reg, flen_next;
    logic                 ok_reg, ok_next;
    logic [ADDR_BITS-1:0] baddr_reg, baddr_next;
    logic [ADDR_BITS-1:0] off_reg, off_next;
    logic [LW-1:0]        top_reg, top_next;
    logic                 mval_reg, mval_next;

    // RAM ports.
    logic                 bw, gw;
    logic [BI-1:0]        bwa, bra;
    logic [GI-1:0]        gwa, gra;
    logic [ADDR_BITS-1:0] bwb, gwb, brb, grb;
    logic [LW-1:0]        bwl, gwl, brl, grl;

    wfba_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_BLOCKS)) u_bbase (
        .aclk, .we(bw), .waddr(bwa), .wdata(bwb), .raddr(bra), .rdata(brb));
    wfba_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_blen (
        .aclk, .we(bw), .waddr(bwa), .wdata(bwl), .raddr(bra), .rdata(brl));
    wfba_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_GAPS)) u_gbase (
        .aclk, .we(gw), .waddr(gwa), .wdata(gwb), .raddr(gra), .rdata(grb));
    wfba_ram #(.WIDTH(LW), .DEPTH(MAX_GAPS)) u_glen (
        .aclk, .we(gw), .waddr(gwa), .wdata(gwl), .raddr(gra), .rdata(grl));

    // Gap entry zero is stored in a register so that reset and clear set it at once.
    logic [ADDR_BITS-1:0] g0b_reg, g0b_next;
    logic [LW-1:0]        g0l_reg, g0l_next;
    logic [GI-1:0]        gra_q;
    logic [ADDR_BITS-1:0] gb_rd;
    logic [LW-1:0]        gl_rd;
    assign gb_rd = (gra_q == '0) ? g0b_reg : grb;
    assign gl_rd = (gra_q == '0) ? g0l_reg : grl;

    logic [LW-1:0]        gend;
    logic [LW-1:0]        cfg_sat;
    assign gend    = LW'(gb_rd) + gl_rd;
    assign cfg_sat = (cfg_wr_data > Span) ? Span : cfg_wr_data;

    assign s_axis_tready = (state_reg == S_IDLE) && !mval_reg;
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = {5'd0, 17'(top_reg), 17'(total_reg - used_reg),
                            AddrW'(off_reg), AddrW'(baddr_reg), ok_reg};

    // Sequencer.
    always_comb begin
        state_next = state_reg; used_next = used_reg; bcnt_next = bcnt_reg;
        gcnt_next = gcnt_reg; gi_next = gi_reg; bi_next = bi_reg; rv_next = 1'b0;
        best_next = best_reg; bestlen_next = bestlen_reg; bestbase_next = bestbase_reg;
        flen_next = flen_reg; ok_next = ok_reg; baddr_next = baddr_reg; off_next = off_reg;
        top_next = top_reg; mval_next = mval_reg;
        g0b_next = g0b_reg; g0l_next = g0l_reg;
        bw = 1'b0; bwa = '0; bwb = '0; bwl = '0; bra = '0;
        gw = 1'b0; gwa = '0; gwb = '0; gwl = '0; gra = '0;
        if (mval_reg && m_axis_tready) begin
            mval_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                ok_next = 1'b0; baddr_next = '0; off_next = '0;
                gi_next = '0; bi_next = '0;
                bestlen_next = '0; best_next = '0;
                if (cmd_reg == CMD_ALLOC) begin
                    if (size_reg == '0 || size_reg > total_reg - used_reg ||
                        gcnt_reg == '0 || bcnt_reg >= BC'(MAX_BLOCKS)) begin
                        state_next = S_TOP;
                    end else begin
                        state_next = S_GSCAN;
                    end
                end else if (cmd_reg == CMD_FREE) begin
                    state_next = S_BFIND;
                end else if (cmd_reg == CMD_LOOKUP || cmd_reg == CMD_EXACT) begin
                    state_next = S_LOOK;
                end else if (cmd_reg == CMD_CLEAR) begin
                    bcnt_next = '0; used_next = '0;
                    g0b_next = '0; g0l_next = total_reg;
                    gcnt_next = (total_reg != '0) ? GC'(1) : '0;
                    ok_next = 1'b1;
                    state_next = S_TOP;
                end else begin
                    state_next = S_TOP;
                end
            end
            // Find the first largest gap, one entry per cycle.
            S_GSCAN: begin
                gra = GI'(gi_reg);
                if (rv_reg) begin
                    if (gi_reg == GC'(1) || gl_rd > bestlen_reg) begin
                        bestlen_next = gl_rd; bestbase_next = gb_rd;
                        best_next = GI'(gi_reg - GC'(1));
                    end
                end
                if (gi_reg < gcnt_reg) begin
                    gi_next = gi_reg + GC'(1); rv_next = 1'b1;
                end else if (rv_reg) begin
                    state_next = S_GSCAN; // wait for the last read data
                end else if (size_reg > bestlen_reg) begin
                    state_next = S_TOP;
                end else begin
                    bi_next = bcnt_reg; state_next = S_BSHIFT;
                end
            end
            // Insertion into the block table from the top down.
            S_BSHIFT: begin
                bra = BI'(bi_reg - BC'(1));
                if (!rv_reg && bi_reg != '0) begin
                    rv_next = 1'b1;
                end else if (rv_reg && brb > bestbase_reg) begin
                    bw = 1'b1; bwa = BI'(bi_reg); bwb = brb; bwl = brl;
                    bi_next = bi_reg - BC'(1);
                end else begin
                    bw = 1'b1; bwa = BI'(bi_reg); bwb = bestbase_reg; bwl = size_reg;
                    bcnt_next = bcnt_reg + BC'(1);
                    used_next = used_reg + size_reg;
                    ok_next = 1'b1; baddr_next = bestbase_reg;
                    if (size_reg < bestlen_reg) begin
                        gw = 1'b1; gwa = best_reg;
                        gwb = bestbase_reg + ADDR_BITS'(size_reg);
                        gwl = bestlen_reg - size_reg;
                        if (best_reg == '0) begin
                            g0b_next = gwb; g0l_next = gwl;
                        end
                        state_next = S_TOP;
                    end else begin
                        gi_next = GC'(best_reg) + GC'(1);
                        state_next = S_GDEL;
                    end
                end
            end
            // Remove an exhausted gap by moving the tail down.
            S_GDEL: begin
                gra = GI'(gi_reg);
                if (gi_reg >= gcnt_reg) begin
                    gcnt_next = gcnt_reg - GC'(1); state_next = S_TOP;
                end else if (!rv_reg) begin
                    rv_next = 1'b1;
                end else begin
                    gw = 1'b1; gwa = GI'(gi_reg - GC'(1)); gwb = gb_rd; gwl = gl_rd;
                    if (gi_reg == GC'(1)) begin
                        g0b_next = gb_rd; g0l_next = gl_rd;
                    end
                    gi_next = gi_reg + GC'(1);
                end
            end
            // Free: find the block by base.
            S_BFIND: begin
                bra = BI'(bi_reg);
                if (bi_reg >= bcnt_reg) begin
                    state_next = S_TOP;
                end else if (!rv_reg) begin
                    rv_next = 1'b1;
                end else if (brb == addr_reg) begin
                    flen_next = brl; gi_next = '0; state_next = S_GFIND;
                end else begin
                    bi_next = bi_reg + BC'(1);
                end
            end
            // Free: find the first gap that ends at or past the address; grow it or insert a new gap.
            S_GFIND: begin
                gra = GI'(gi_reg);
                if (gi_reg < gcnt_reg && !rv_reg) begin
                    rv_next = 1'b1;
                end else if (gi_reg < gcnt_reg && LW'(addr_reg) > gend) begin
                    gi_next = gi_reg + GC'(1);
                end else if (gi_reg < gcnt_reg && LW'(addr_reg) == gend) begin
                    gw = 1'b1; gwa = GI'(gi_reg); gwb = gb_rd; gwl = gl_rd + flen_reg;
                    if (gi_reg == '0) begin
                        g0l_next = gwl;
                    end
                    state_next = S_BDEL; bi_next = bi_reg + BC'(1);
                end else if (gi_reg < gcnt_reg &&
                             LW'(addr_reg) + flen_reg == LW'(gb_rd)) begin
                    gw = 1'b1; gwa = GI'(gi_reg); gwb = addr_reg; gwl = gl_rd + flen_reg;
                    if (gi_reg == '0) begin
                        g0b_next = gwb; g0l_next = gwl;
                    end
                    state_next = S_BDEL; bi_next = bi_reg + BC'(1);
                end else if (gcnt_reg >= GC'(MAX_GAPS)) begin
                    state_next = S_TOP;
                end else begin
                    best_next = GI'(gi_reg); gi_next = gcnt_reg;
                    state_next = S_GINS;
                end
            end
            // Free: open a slot in the gap list from the top down.
            S_GINS: begin
                gra = GI'(gi_reg - GC'(1));
                if (gi_reg > GC'(best_reg)) begin
                    if (!rv_reg) begin
                        rv_next = 1'b1;
                    end else begin
                        gw = 1'b1; gwa = GI'(gi_reg); gwb = gb_rd; gwl = gl_rd;
                        gi_next = gi_reg - GC'(1);
                    end
                end else begin
                    gw = 1'b1; gwa = best_reg; gwb = addr_reg; gwl = flen_reg;
                    if (best_reg == '0) begin
                        g0b_next = addr_reg; g0l_next = flen_reg;
                    end
                    gcnt_next = gcnt_reg + GC'(1);
                    state_next = S_BDEL; bi_next = bi_reg + BC'(1);
                end
            end
            // Free: close the block table over the freed entry.
            S_BDEL: begin
                bra = BI'(bi_reg);
                if (bi_reg >= bcnt_reg) begin
                    bcnt_next = bcnt_reg - BC'(1);
                    used_next = used_reg - flen_reg;
                    ok_next = 1'b1; baddr_next = addr_reg;
                    state_next = S_TOP;
                end else if (!rv_reg) begin
                    rv_next = 1'b1;
                end else begin
                    bw = 1'b1; bwa = BI'(bi_reg - BC'(1)); bwb = brb; bwl = brl;
                    bi_next = bi_reg + BC'(1);
                end
            end
            // Lookups walk the block table in base order.
            S_LOOK: begin
                bra = BI'(bi_reg);
                if (bi_reg >= bcnt_reg) begin
                    state_next = S_TOP;
                end else if (!rv_reg) begin
                    rv_next = 1'b1;
                end else if ((cmd_reg == CMD_EXACT && brb == addr_reg) ||
                             (cmd_reg == CMD_LOOKUP && addr_reg >= brb &&
                              LW'(addr_reg) < LW'(brb) + brl)) begin
                    ok_next = 1'b1; baddr_next = brb;
                    off_next = (cmd_reg == CMD_LOOKUP) ? addr_reg - brb : '0;
                    state_next = S_TOP;
                end else begin
                    bi_next = bi_reg + BC'(1);
                end
            end
            // Read the highest block for the top address.
            S_TOP: begin
                bra = BI'(bcnt_reg - BC'(1));
                state_next = S_TOPW;
            end
            S_TOPW: begin
                top_next = (bcnt_reg == '0) ? '0 : LW'(brb) + brl;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mval_reg) begin
                    mval_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; mval_reg <= 1'b0; total_reg <= Span;
            bcnt_reg <= '0; gcnt_reg <= GC'(1); used_reg <= '0;
            g0b_reg <= '0; g0l_reg <= Span; rv_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            total_reg <= cfg_sat; bcnt_reg <= '0; used_reg <= '0;
            g0b_reg <= '0; g0l_reg <= cfg_sat;
            gcnt_reg <= (cfg_sat != '0) ? GC'(1) : '0;
            mval_reg <= mval_next; state_reg <= state_next; rv_reg <= rv_next;
        end else begin
            state_reg <= state_next; mval_reg <= mval_next; bcnt_reg <= bcnt_next;
            gcnt_reg <= gcnt_next; used_reg <= used_next; rv_reg <= rv_next;
            g0b_reg <= g0b_next; g0l_reg <= g0l_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_reg  <= s_axis_tdata[2:0];
            size_reg <= LW'(s_axis_tdata[19:3]);
            addr_reg <= ADDR_BITS'(s_axis_tdata[35:20]);
        end
        gra_q <= gra;
        gi_reg <= gi_next; bi_reg <= bi_next; best_reg <= best_next;
        bestlen_reg <= bestlen_next; bestbase_reg <= bestbase_next;
        flen_reg <= flen_next; ok_reg <= ok_next; baddr_reg <= baddr_next;
        off_reg <= off_next; top_reg <= top_next;
    end
endmodule

[sv/wfba_checker.sv]
// Port-level checker for the worst-fit block allocator, bound to the top level.
module wfba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    // A waiting result holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No new command is taken while a result waits.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready with pending result");

    // An accepted command is not followed by ready in the next cycle.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after acceptance");

    // A failed result carries no offset.
    a_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:17] == 16'd0)
        else $error("offset on failure");
endmodule

bind worst_fit_block_allocator_unit wfba_checker u_wfba_checker (
    .aclk, .aresetn, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
